// ===== rtl/dhf_pkg.sv =====
// ----------------------------------------------------------------------------
// dhf_pkg
// Shared constants, types and register codes of the 3x3 depth hole filler.
// ----------------------------------------------------------------------------
package dhf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int DEPTH_BITS = 16;

    // Column index into the line stores.
    localparam int COL_W = $clog2(MAX_WIDTH);

    // Configuration register widths and reset values.
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

    // The input row runs ahead of the output row by up to one full frame of
    // items when the width shrinks in mid-frame, so it gets one spare bit.
    localparam int IN_ROW_W  = HEIGHT_REG_W + 1;
    localparam int OUT_ROW_W = HEIGHT_REG_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = HEIGHT_REG_W;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Item kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Neighbor sum and count: eight neighbors at most.
    localparam int SUM_W = DEPTH_BITS + 3;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] FILL_MIN_COUNT = CNT_W'(3);

    // Iterative divider: two quotient bits per cycle.
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_CYCLES    = (SUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_PAD       = DIV_CYCLES * DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    typedef logic [DEPTH_BITS-1:0] depth_t;

    // One line store entry holds the two previous lines at one column.
    typedef struct packed {
        depth_t upper;
        depth_t middle;
    } line_entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [COL_W-1:0]  rd_addr;
        logic              wr_en;
        logic [COL_W-1:0]  wr_addr;
        line_entry_t       wr_data;
    } mem_req_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        depth_t quotient;
    } div_rsp_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } border_t;

endpackage

// ===== rtl/depth_hole_fill_3x3.sv =====
// ----------------------------------------------------------------------------
// depth_hole_fill_3x3
// Fills holes (zero depth) of a raster-order depth image with the truncated
// mean of their non-zero 3x3 neighbors when more than three are non-zero.
//
//   Channel   Ports                                        Direction
//   config    cfg_valid/cfg_ready, cfg_index, cfg_data     in
//   pixels    s_valid/s_ready, s_kind, s_in_depth          in
//   results   m_valid/m_ready, m_out_depth, m_was_filled,  out
//             m_end_of_frame
//
// One item is worked on at a time: an item with no result goes through the
// accept and update steps, a pixel that passes through also through evaluate
// and output, and a filled hole waits for the divider in between. The line
// store is read at the accept step and written back in the update step.
// A result waits in the output register without holding back the next input
// transfer; only the transfer of the following result waits for it.
// Reset is synchronous and needs no clearing pass: line store contents that
// were never written only reach window positions that the border masks off.
// ----------------------------------------------------------------------------
module depth_hole_fill_3x3 (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dhf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dhf_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [dhf_pkg::DEPTH_BITS-1:0]  s_in_depth,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dhf_pkg::DEPTH_BITS-1:0]  m_out_depth,
    output logic                            m_was_filled,
    output logic                            m_end_of_frame
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;

    // Configuration.
    logic [dhf_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [dhf_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [dhf_pkg::WIDTH_REG_W-1:0]  w_eff;
    logic [dhf_pkg::HEIGHT_REG_W-1:0] h_eff;

    // Position counters.
    logic [dhf_pkg::COL_W-1:0]     in_col_reg;
    logic [dhf_pkg::IN_ROW_W-1:0]  in_row_reg;
    logic [dhf_pkg::COL_W-1:0]     out_col_reg;
    logic [dhf_pkg::OUT_ROW_W-1:0] out_row_reg;

    // Accepted item.
    logic            kind_reg;
    dhf_pkg::depth_t depth_reg;

    dhf_pkg::depth_t win_reg [3][3];
    dhf_pkg::border_t border_reg;
    dhf_pkg::border_t border;

    // Result waiting for the output register.
    dhf_pkg::depth_t res_depth_reg;
    logic            res_filled_reg;

    logic            m_valid_reg;
    dhf_pkg::depth_t m_out_depth_reg;
    logic            m_was_filled_reg;
    logic            m_end_of_frame_reg;

    dhf_pkg::mem_req_t    mem_req;
    dhf_pkg::line_entry_t mem_rd;
    dhf_pkg::div_req_t    div_req;
    dhf_pkg::div_rsp_t    div_rsp;

    logic                            s_xfer;
    logic                            pending;
    logic                            skip;
    logic                            emit;
    dhf_pkg::depth_t                 d_eff;
    logic [dhf_pkg::WIDTH_REG_W-1:0] col_inc;
    logic                            col_wrap;
    logic [dhf_pkg::WIDTH_REG_W-1:0] ocol_inc;
    logic                            ocol_wrap;
    logic [dhf_pkg::SUM_W-1:0]       nb_sum;
    logic [dhf_pkg::CNT_W-1:0]       nb_cnt;
    logic                            fill;
    logic                            out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = dhf_pkg::WIDTH_REG_W'(1);
        end else if (width_reg > dhf_pkg::WIDTH_REG_W'(dhf_pkg::MAX_WIDTH)) begin
            w_eff = dhf_pkg::WIDTH_REG_W'(dhf_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? dhf_pkg::HEIGHT_REG_W'(1) : height_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= dhf_pkg::WIDTH_RESET;
            height_reg <= dhf_pkg::HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dhf_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data[dhf_pkg::WIDTH_REG_W-1:0];
                end
                dhf_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Update step: decisions from the counters as they stand before the item.
    always_comb begin
        pending = (in_col_reg != '0) || (in_row_reg != '0);
        skip    = (kind_reg == dhf_pkg::KIND_FLUSH) && !pending;
        if ((kind_reg == dhf_pkg::KIND_FLUSH) ||
            (in_row_reg >= dhf_pkg::IN_ROW_W'(h_eff))) begin
            d_eff = '0;
        end else begin
            d_eff = depth_reg;
        end
        emit = (in_row_reg >= dhf_pkg::IN_ROW_W'(2)) ||
               ((in_row_reg == dhf_pkg::IN_ROW_W'(1)) && (in_col_reg != '0));
        col_inc  = dhf_pkg::WIDTH_REG_W'(in_col_reg) + 1'b1;
        col_wrap = (col_inc >= w_eff);
        ocol_inc = dhf_pkg::WIDTH_REG_W'(out_col_reg) + 1'b1;
        ocol_wrap = (ocol_inc >= w_eff);

        border.left   = (out_col_reg == '0);
        border.right  = (dhf_pkg::WIDTH_REG_W'(out_col_reg) >= (w_eff - 1'b1));
        border.top    = (out_row_reg == '0);
        border.bottom = (out_row_reg >= (h_eff - 1'b1));
        border.last   = border.right && border.bottom;
    end

    // Line store: read at the input transfer, written back in the update step.
    always_comb begin
        mem_req.rd_en          = s_xfer;
        mem_req.rd_addr        = in_col_reg;
        mem_req.wr_en          = (state_reg == ST_UPDATE) && !skip;
        mem_req.wr_addr        = in_col_reg;
        mem_req.wr_data.upper  = mem_rd.middle;
        mem_req.wr_data.middle = d_eff;
    end

    dhf_line_mem u_line_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    // Neighbor sum and count over the eight neighbors, masked at the borders.
    always_comb begin
        nb_sum = '0;
        nb_cnt = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!((r == 1) && (c == 1)) &&
                    !((r == 0) && border_reg.top) && !((r == 2) && border_reg.bottom) &&
                    !((c == 0) && border_reg.left) && !((c == 2) && border_reg.right)) begin
                    nb_sum = nb_sum + dhf_pkg::SUM_W'(win_reg[r][c]);
                    if (win_reg[r][c] != '0) begin
                        nb_cnt = nb_cnt + 1'b1;
                    end
                end
            end
        end
        fill = (win_reg[1][1] == '0) && (nb_cnt > dhf_pkg::FILL_MIN_COUNT);
    end

    always_comb begin
        div_req.start    = (state_reg == ST_EVAL) && fill;
        div_req.dividend = nb_sum;
        div_req.divisor  = nb_cnt;
    end

    dhf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = (!skip && emit) ? ST_EVAL : ST_IDLE;
            end
            ST_EVAL: begin
                state_next = fill ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state: FSM, counters, window and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_UPDATE) && !skip) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= mem_rd.upper;
                win_reg[1][2] <= mem_rd.middle;
                win_reg[2][2] <= d_eff;

                if (emit && border.last) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else begin
                    if (col_wrap) begin
                        in_col_reg <= '0;
                        // Saturation keeps the row comparisons with zero, two and the height true past the frame.
                        if (in_row_reg != '1) begin
                            in_row_reg <= in_row_reg + 1'b1;
                        end
                    end else begin
                        in_col_reg <= col_inc[dhf_pkg::COL_W-1:0];
                    end
                    if (emit) begin
                        if (ocol_wrap) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                        end else begin
                            out_col_reg <= ocol_inc[dhf_pkg::COL_W-1:0];
                        end
                    end
                end
            end
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            kind_reg  <= s_kind;
            depth_reg <= s_in_depth;
        end
        if (state_reg == ST_UPDATE) begin
            border_reg <= border;
        end
        if (state_reg == ST_EVAL) begin
            res_depth_reg  <= win_reg[1][1];
            res_filled_reg <= 1'b0;
        end else if ((state_reg == ST_DIV) && div_rsp.done) begin
            res_depth_reg  <= div_rsp.quotient;
            res_filled_reg <= 1'b1;
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_out_depth_reg    <= res_depth_reg;
            m_was_filled_reg   <= res_filled_reg;
            m_end_of_frame_reg <= border_reg.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_depth    = m_out_depth_reg;
    assign m_was_filled   = m_was_filled_reg;
    assign m_end_of_frame = m_end_of_frame_reg;

endmodule

// ===== rtl/dhf_line_mem.sv =====
// ----------------------------------------------------------------------------
// dhf_line_mem
// Line store memory: the two previous image lines packed per column, one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module dhf_line_mem (
    input  logic                 aclk,
    input  dhf_pkg::mem_req_t    req,
    output dhf_pkg::line_entry_t rd_data
);

    dhf_pkg::line_entry_t mem [dhf_pkg::MAX_WIDTH];
    dhf_pkg::line_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dhf_div.sv =====
// ----------------------------------------------------------------------------
// dhf_div
// Iterative restoring divider for the neighbor mean: neighbor sum divided by
// the non-zero neighbor count, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module dhf_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  dhf_pkg::div_req_t req,
    output dhf_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [dhf_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [dhf_pkg::DIV_PAD-1:0]     num_reg;
    logic [dhf_pkg::DIV_PAD-1:0]     num_next;
    logic [dhf_pkg::DIV_PAD-1:0]     quo_reg;
    logic [dhf_pkg::DIV_PAD-1:0]     quo_next;
    logic [dhf_pkg::CNT_W-1:0]       rem_reg;
    logic [dhf_pkg::CNT_W-1:0]       rem_next;
    logic [dhf_pkg::CNT_W-1:0]       den_reg;
    logic [dhf_pkg::CNT_W-1:0]       trial;
    logic                            last_step;

    // The remainder stays below the divisor, so the top remainder bit is
    // always free to take the next dividend bit.
    always_comb begin
        rem_next = rem_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int k = 0; k < dhf_pkg::DIV_STEP_BITS; k++) begin
            trial    = {rem_next[dhf_pkg::CNT_W-2:0], num_next[dhf_pkg::DIV_PAD-1]};
            num_next = {num_next[dhf_pkg::DIV_PAD-2:0], 1'b0};
            if (trial >= den_reg) begin
                rem_next = trial - den_reg;
                quo_next = {quo_next[dhf_pkg::DIV_PAD-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_next[dhf_pkg::DIV_PAD-2:0], 1'b0};
            end
        end
    end

    assign last_step = (cnt_reg == dhf_pkg::DIV_CNT_W'(dhf_pkg::DIV_CYCLES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= dhf_pkg::DIV_PAD'(req.dividend);
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= req.divisor;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // The mean never exceeds the largest neighbor, so the low bits hold it.
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[dhf_pkg::DEPTH_BITS-1:0];

endmodule

// ===== rtl/dhf_checker.sv =====
// ----------------------------------------------------------------------------
// dhf_checker
// Port-level checks of the depth hole filler, bound to its top level.
// ----------------------------------------------------------------------------
module dhf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [dhf_pkg::DEPTH_BITS-1:0]  m_out_depth,
    input logic                            m_was_filled,
    input logic                            m_end_of_frame
);

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_depth) &&
        $stable(m_was_filled) && $stable(m_end_of_frame))
        else $error("result changed while stalled");

    // A mean of at least four non-zero neighbors can never be zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_filled |-> m_out_depth != '0)
        else $error("filled hole left at zero depth");

    // One item at a time: no input transfer right after another.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken in back-to-back cycles");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind depth_hole_fill_3x3 dhf_checker u_dhf_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_depth    (m_out_depth),
    .m_was_filled   (m_was_filled),
    .m_end_of_frame (m_end_of_frame)
);
